>>> rtl/core/cpp_pkg.sv
`timescale 1ns / 1ps
// cpp_pkg: shared types, register indexes and constants of the cliquet path payoff block.
// No dependencies; cpp_div, cpp_seq and cliquet_path_payoff take names from here by scope.
package cpp_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    // configuration register indexes
    localparam logic [2:0] REG_OPTION_KIND     = 3'd0;
    localparam logic [2:0] REG_REDEMPTION_MODE = 3'd1;
    localparam logic [2:0] REG_STRIKE_RATIO    = 3'd2;
    localparam logic [2:0] REG_COUPON_CEILING  = 3'd3;
    localparam logic [2:0] REG_COUPON_BASE     = 3'd4;
    localparam logic [2:0] REG_TOTAL_CEILING   = 3'd5;
    localparam logic [2:0] REG_TOTAL_BASE      = 3'd6;
    localparam logic [2:0] REG_ACCRUED_AMOUNT  = 3'd7;

    // vanilla payoff kinds; any other code acts as straddle
    localparam logic [1:0] KIND_CALL = 2'd0;
    localparam logic [1:0] KIND_PUT  = 2'd1;

    // ln2 in Q4.28
    localparam logic signed [33:0] LN2_Q28 = 34'sd186065279;

    localparam logic [31:0] STRIKE_RESET = 32'h0100_0000;
    localparam logic [31:0] ALL32        = 32'hFFFF_FFFF;
    localparam logic [39:0] MAX40        = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  option_kind;
        logic        redemption_mode;
        logic [31:0] strike_ratio;
        logic [31:0] coupon_ceiling;
        logic [31:0] coupon_base;
        logic [31:0] total_ceiling;
        logic [31:0] total_base;
        logic [31:0] accrued_amount;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/core/cpp_mul.sv
`timescale 1ns / 1ps
// cpp_mul: shared 33x32 multiplier with a registered product.
// Depends on nothing; operands are chosen by the sequencer.
module cpp_mul (
    input  logic        aclk,
    input  logic [32:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [64:0] mul_p
);

    logic [64:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= {32'd0, mul_a} * {33'd0, mul_b};
    end

    assign mul_p = prod_reg;

endmodule

>>> rtl/core/cpp_div.sv
`timescale 1ns / 1ps
// cpp_div: bit-serial restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Quotients that do not fit 32 bits saturate to all ones. Uses cpp_pkg request and response types.
module cpp_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  cpp_pkg::div_req_t div_req,
    output cpp_pkg::div_rsp_t div_rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] dq_reg;
    logic [31:0] dvs_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg, dq_reg[31]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                if (div_req.dividend[63:32] >= div_req.divisor) begin
                    // quotient overflows: saturate
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            rem_reg <= div_req.dividend[63:32];
            dvs_reg <= div_req.divisor;
            if (div_req.dividend[63:32] >= div_req.divisor) begin
                dq_reg <= cpp_pkg::ALL32;
            end else begin
                dq_reg <= div_req.dividend[31:0];
            end
        end else if (busy_reg) begin
            rem_reg <= fits ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
            dq_reg  <= {dq_reg[30:0], fits};
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.busy     = busy_reg;
    assign div_rsp.quotient = dq_reg;

endmodule

>>> rtl/core/cpp_seq.sv
`timescale 1ns / 1ps
// cpp_seq: step sequencer and path state; drives the shared multiplier and divider.
// Depends on cpp_pkg (cfg_t, divider request and response types, constants).
module cpp_seq #(
    parameter int VALUE_WIDTH = cpp_pkg::VALUE_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cpp_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              path_start,
    input  logic [31:0]       start_level,
    input  logic [31:0]       prior_fixing,
    input  logic [31:0]       log_step,
    input  logic              fixing_here,
    input  logic [31:0]       discount_factor,
    input  logic              path_end,
    input  logic              out_free,
    output logic              res_valid,
    output logic [31:0]       res_value,
    output logic              res_cap,
    output cpp_pkg::div_req_t div_req,
    input  cpp_pkg::div_rsp_t div_rsp,
    output logic [32:0]       mul_a,
    output logic [31:0]       mul_b,
    input  logic [64:0]       mul_p
);

    localparam logic [39:0] VMAX = (VALUE_WIDTH >= 32) ? 40'h00_FFFF_FFFF
                                 : ((40'd1 << VALUE_WIDTH) - 40'd1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RED     = 4'd1;
    localparam logic [3:0] ST_T_MUL   = 4'd2;
    localparam logic [3:0] ST_T_RCP   = 4'd3;
    localparam logic [3:0] ST_T_QUO   = 4'd4;
    localparam logic [3:0] ST_L_MUL   = 4'd5;
    localparam logic [3:0] ST_L_SHIFT = 4'd6;
    localparam logic [3:0] ST_V_MUL   = 4'd7;
    localparam logic [3:0] ST_V_DIV   = 4'd8;
    localparam logic [3:0] ST_V_WAIT  = 4'd9;
    localparam logic [3:0] ST_C_MUL   = 4'd10;
    localparam logic [3:0] ST_C_ACC   = 4'd11;
    localparam logic [3:0] ST_FIN     = 4'd12;
    localparam logic [3:0] ST_E_MUL   = 4'd13;
    localparam logic [3:0] ST_OUT     = 4'd14;

    logic [3:0]         state_reg;
    logic [31:0]        level_reg;
    logic [31:0]        fix_lvl_reg;
    logic               known_reg;
    logic [31:0]        total_reg;
    logic [39:0]        disc_reg;
    logic               capped_reg;
    logic signed [33:0] r_reg;
    logic signed [4:0]  k_reg;
    logic [32:0]        term_reg;
    logic [33:0]        sum_reg;
    logic [3:0]         i_reg;
    logic [31:0]        c_reg;
    logic               fix_here_reg;
    logic               end_reg;
    logic [31:0]        df_reg;

    logic        take;
    logic        cap_on;
    logic [5:0]  shamt;
    logic [63:0] grown;
    logic [31:0] lvl_grow;
    logic [32:0] rcp_m;
    logic [5:0]  rcp_sh;
    logic [64:0] rcp_q;
    logic [63:0] strike_amt;
    logic [63:0] spot_amt;
    logic [63:0] payoff;
    logic [31:0] c_floor;
    logic [31:0] c_lim;
    logic [32:0] red_sum;
    logic [31:0] red_tot;
    logic [31:0] room;
    logic [31:0] c_room;
    logic [32:0] cpn_sum;
    logic [40:0] disc_sum;
    logic [31:0] end_base;
    logic [39:0] end_raw;
    logic [39:0] end_val;

    assign in_ready = state_reg == ST_IDLE;
    assign take     = in_valid && in_ready;
    assign cap_on   = cfg.total_ceiling != cpp_pkg::ALL32;

    // level growth: product shifted by 31 - k, clamped to [1, 2^32-1]
    assign shamt    = 6'd31 - {k_reg[4], k_reg};
    assign grown    = mul_p[63:0] >> shamt;
    assign lvl_grow = (|grown[63:32]) ? cpp_pkg::ALL32
                    : (grown[31:0] == 32'd0) ? 32'd1 : grown[31:0];

    // series term / i as (term * m) >> s, exact for any term below 2^32
    always_comb begin
        case (i_reg)
            4'd1:    begin rcp_m = 33'h1_0000_0000; rcp_sh = 6'd32; end
            4'd2:    begin rcp_m = 33'h1_0000_0000; rcp_sh = 6'd33; end
            4'd3:    begin rcp_m = 33'h1_5555_5556; rcp_sh = 6'd34; end
            4'd4:    begin rcp_m = 33'h1_0000_0000; rcp_sh = 6'd34; end
            4'd5:    begin rcp_m = 33'h1_9999_999A; rcp_sh = 6'd35; end
            4'd6:    begin rcp_m = 33'h1_5555_5556; rcp_sh = 6'd35; end
            4'd7:    begin rcp_m = 33'h1_2492_4925; rcp_sh = 6'd35; end
            4'd8:    begin rcp_m = 33'h1_0000_0000; rcp_sh = 6'd35; end
            4'd9:    begin rcp_m = 33'h1_C71C_71C8; rcp_sh = 6'd36; end
            4'd10:   begin rcp_m = 33'h1_9999_999A; rcp_sh = 6'd36; end
            4'd11:   begin rcp_m = 33'h1_745D_1746; rcp_sh = 6'd36; end
            default: begin rcp_m = 33'h1_5555_5556; rcp_sh = 6'd36; end
        endcase
    end

    assign rcp_q = mul_p >> rcp_sh;

    assign strike_amt = mul_p[63:0];
    assign spot_amt   = {8'd0, level_reg, 24'd0};
    always_comb begin
        case (cfg.option_kind)
            cpp_pkg::KIND_CALL: payoff = (spot_amt > strike_amt) ? spot_amt - strike_amt : '0;
            cpp_pkg::KIND_PUT:  payoff = (strike_amt > spot_amt) ? strike_amt - spot_amt : '0;
            default:            payoff = (spot_amt > strike_amt) ? spot_amt - strike_amt
                                                                 : strike_amt - spot_amt;
        endcase
    end

    // floor first, then cap
    assign c_floor = (div_rsp.quotient < cfg.coupon_base) ? cfg.coupon_base : div_rsp.quotient;
    assign c_lim   = (c_floor > cfg.coupon_ceiling) ? cfg.coupon_ceiling : c_floor;
    assign red_sum = {1'b0, total_reg} + {1'b0, c_lim};
    assign red_tot = red_sum[32] ? cpp_pkg::ALL32 : red_sum[31:0];
    assign room    = (cfg.total_ceiling > total_reg) ? cfg.total_ceiling - total_reg : '0;
    assign c_room  = (cap_on && c_lim > room) ? room : c_lim;
    assign cpn_sum = {1'b0, total_reg} + {1'b0, c_room};

    assign disc_sum = {1'b0, disc_reg} + {8'd0, mul_p[63:31]};

    assign end_base = (total_reg < cfg.total_base) ? cfg.total_base : total_reg;
    assign end_raw  = cfg.redemption_mode ? {7'd0, mul_p[63:31]} : disc_reg;
    assign end_val  = (end_raw > VMAX) ? VMAX : end_raw;

    always_comb begin
        mul_a = {1'b0, cfg.strike_ratio};
        mul_b = fix_lvl_reg;
        case (state_reg)
            ST_T_MUL: begin
                mul_a = term_reg;
                mul_b = {r_reg[27:0], 4'd0};
            end
            ST_T_RCP: begin
                mul_a = rcp_m;
                mul_b = mul_p[63:32];
            end
            ST_L_MUL: begin
                mul_a = {1'b0, level_reg};
                mul_b = sum_reg[32:1];
            end
            ST_C_MUL: begin
                mul_a = {1'b0, c_reg};
                mul_b = df_reg;
            end
            ST_E_MUL, ST_OUT: begin
                mul_a = {1'b0, end_base};
                mul_b = df_reg;
            end
            default: begin
                mul_a = {1'b0, cfg.strike_ratio};
                mul_b = fix_lvl_reg;
            end
        endcase
    end

    always_comb begin
        div_req.start    = (state_reg == ST_V_DIV);
        div_req.dividend = payoff;
        div_req.divisor  = fix_lvl_reg;
    end

    assign res_valid = (state_reg == ST_OUT) && out_free;
    assign res_value = end_val[31:0];
    assign res_cap   = capped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            level_reg   <= '0;
            fix_lvl_reg <= '0;
            known_reg   <= 1'b0;
            total_reg   <= '0;
            disc_reg    <= '0;
            capped_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        if (path_start) begin
                            level_reg   <= start_level;
                            fix_lvl_reg <= prior_fixing;
                            known_reg   <= prior_fixing != 32'd0;
                            total_reg   <= cfg.accrued_amount;
                            disc_reg    <= '0;
                            capped_reg  <= 1'b0;
                        end
                        state_reg <= ST_RED;
                    end
                end
                ST_RED: begin
                    // bring the log step into [0, ln2)
                    if (r_reg < 0) begin
                        state_reg <= ST_RED;
                    end else if (r_reg >= cpp_pkg::LN2_Q28) begin
                        state_reg <= ST_RED;
                    end else begin
                        state_reg <= ST_T_MUL;
                    end
                end
                ST_T_MUL: state_reg <= ST_T_RCP;
                ST_T_RCP: state_reg <= ST_T_QUO;
                ST_T_QUO: state_reg <= (i_reg == 4'd12) ? ST_L_MUL : ST_T_MUL;
                ST_L_MUL: state_reg <= ST_L_SHIFT;
                ST_L_SHIFT: begin
                    level_reg <= lvl_grow;
                    if (fix_here_reg || end_reg) begin
                        if (known_reg && fix_lvl_reg != 32'd0) begin
                            state_reg <= ST_V_MUL;
                        end else begin
                            fix_lvl_reg <= lvl_grow;
                            known_reg   <= 1'b1;
                            state_reg   <= ST_FIN;
                        end
                    end else begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_V_MUL: state_reg <= ST_V_DIV;
                ST_V_DIV: state_reg <= ST_V_WAIT;
                ST_V_WAIT: begin
                    if (div_rsp.done) begin
                        if (cfg.redemption_mode) begin
                            if (cap_on && red_tot >= cfg.total_ceiling) begin
                                // pin at the cap and freeze the previous fixing
                                total_reg  <= cfg.total_ceiling;
                                capped_reg <= 1'b1;
                            end else begin
                                total_reg   <= red_tot;
                                fix_lvl_reg <= level_reg;
                                known_reg   <= 1'b1;
                            end
                            state_reg <= ST_FIN;
                        end else begin
                            total_reg <= cpn_sum[32] ? cpp_pkg::ALL32 : cpn_sum[31:0];
                            state_reg <= ST_C_MUL;
                        end
                    end
                end
                ST_C_MUL: state_reg <= ST_C_ACC;
                ST_C_ACC: begin
                    disc_reg <= disc_sum[40] ? cpp_pkg::MAX40 : disc_sum[39:0];
                    if (cap_on && total_reg >= cfg.total_ceiling) begin
                        capped_reg <= 1'b1;
                    end else begin
                        fix_lvl_reg <= level_reg;
                        known_reg   <= 1'b1;
                    end
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (!end_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= cfg.redemption_mode ? ST_E_MUL : ST_OUT;
                    end
                end
                ST_E_MUL: state_reg <= ST_OUT;
                ST_OUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        if (take) begin
            r_reg        <= {{2{log_step[31]}}, log_step};
            k_reg        <= '0;
            fix_here_reg <= fixing_here;
            end_reg      <= path_end;
            df_reg       <= discount_factor;
        end
        if (state_reg == ST_RED) begin
            if (r_reg < 0) begin
                r_reg <= r_reg + cpp_pkg::LN2_Q28;
                k_reg <= k_reg - 5'sd1;
            end else if (r_reg >= cpp_pkg::LN2_Q28) begin
                r_reg <= r_reg - cpp_pkg::LN2_Q28;
                k_reg <= k_reg + 5'sd1;
            end else begin
                term_reg <= 33'h1_0000_0000;
                sum_reg  <= 34'h1_0000_0000;
                i_reg    <= 4'd1;
            end
        end
        if (state_reg == ST_T_QUO) begin
            term_reg <= {1'b0, rcp_q[31:0]};
            sum_reg  <= sum_reg + {2'd0, rcp_q[31:0]};
            i_reg    <= i_reg + 4'd1;
        end
        if (state_reg == ST_V_WAIT && div_rsp.done) begin
            c_reg <= c_room;
        end
    end

`ifndef SYNTHESIS
    a_take_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> state_reg == ST_RED)
        else $error("item taken outside idle");
    a_level_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN |-> level_reg != 32'd0)
        else $error("grown level is zero");
    a_div_free : assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
    a_result_end : assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> end_reg)
        else $error("result on a step that is not a path end");
`endif

endmodule

>>> rtl/core/cliquet_path_payoff.sv
`timescale 1ns / 1ps
// Each item passes through range reduction, a twelve-term series on the shared multiplier and,
// at a fixing or path end with a known previous fixing, a bit-serial ratio divide whose quotient
// saturates to all ones when the ratio does not fit. One item is in flight at a time: the next
// item is taken once the previous one is done, while a finished result may still wait in the
// output register.
// Reset: synchronous, active-low aresetn clears the path state and loads register defaults.
// Depends on cpp_pkg, cpp_mul, cpp_div and cpp_seq.
module cliquet_path_payoff #(
    parameter int VALUE_WIDTH = cpp_pkg::VALUE_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_level [31:0], prior_fixing [63:32], log_step [95:64], discount_factor [127:96]
    input  logic [127:0] s_axis_tdata,
    // path_start [0], fixing_here [1]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // path_value [31:0]
    output logic [31:0]  m_axis_tdata,
    // cap_reached [0]
    output logic [0:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    cpp_pkg::cfg_t     cfg_reg;
    cpp_pkg::div_req_t div_req;
    cpp_pkg::div_rsp_t div_rsp;
    logic [32:0]       mul_a;
    logic [31:0]       mul_b;
    logic [64:0]       mul_p;
    logic              out_free;
    logic              res_valid;
    logic [31:0]       res_value;
    logic              res_cap;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic              m_user_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.option_kind     <= cpp_pkg::KIND_CALL;
            cfg_reg.redemption_mode <= 1'b0;
            cfg_reg.strike_ratio    <= cpp_pkg::STRIKE_RESET;
            cfg_reg.coupon_ceiling  <= cpp_pkg::ALL32;
            cfg_reg.coupon_base     <= '0;
            cfg_reg.total_ceiling   <= cpp_pkg::ALL32;
            cfg_reg.total_base      <= '0;
            cfg_reg.accrued_amount  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cpp_pkg::REG_OPTION_KIND:     cfg_reg.option_kind     <= cfg_data[1:0];
                cpp_pkg::REG_REDEMPTION_MODE: cfg_reg.redemption_mode <= cfg_data[0];
                cpp_pkg::REG_STRIKE_RATIO:    cfg_reg.strike_ratio    <= cfg_data;
                cpp_pkg::REG_COUPON_CEILING:  cfg_reg.coupon_ceiling  <= cfg_data;
                cpp_pkg::REG_COUPON_BASE:     cfg_reg.coupon_base     <= cfg_data;
                cpp_pkg::REG_TOTAL_CEILING:   cfg_reg.total_ceiling   <= cfg_data;
                cpp_pkg::REG_TOTAL_BASE:      cfg_reg.total_base      <= cfg_data;
                cpp_pkg::REG_ACCRUED_AMOUNT:  cfg_reg.accrued_amount  <= cfg_data;
                default: ;
            endcase
        end
    end

    cpp_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    cpp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    cpp_seq #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .path_start      (s_axis_tuser[0]),
        .start_level     (s_axis_tdata[31:0]),
        .prior_fixing    (s_axis_tdata[63:32]),
        .log_step        (s_axis_tdata[95:64]),
        .fixing_here     (s_axis_tuser[1]),
        .discount_factor (s_axis_tdata[127:96]),
        .path_end        (s_axis_tlast),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res_value       (res_value),
        .res_cap         (res_cap),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .mul_a           (mul_a),
        .mul_b           (mul_b),
        .mul_p           (mul_p)
    );

    // output register: hold the result until the transfer completes
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res_value;
            m_user_reg <= res_cap;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

endmodule
